// File: rtl/mte_pkg.sv
`timescale 1ns / 1ps

package mte_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DELAY_W     = 13;
    localparam int GAIN_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int MIX_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // at most 29 echoes of |g*x| < 2^31 each
    localparam int ACC_W       = 37;
    // Q0.16 gain times Q1.15 mix leaves 31 fraction bits above Q1.15
    localparam int FRAC_SHIFT  = 31;

    localparam logic [MIX_W-1:0]   MIX_UNITY   = 16'h8000;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd2205;
    localparam logic [GAIN_W-1:0]  DECAY_RESET = 16'd32768;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd30;
    localparam logic [MIX_W-1:0]   MIX_RESET   = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 3'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_sample;
        logic                          last_sample;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_sample;
        logic                          clipped;
        logic                          end_of_clip;
    } result_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic use_tap;
    } tap_ctl_t;

endpackage

// File: rtl/mte_ram.sv
`timescale 1ns / 1ps

module mte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mte_tap_mac.sv
`timescale 1ns / 1ps

module mte_tap_mac (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  mte_pkg::tap_ctl_t                          ctl,
    input  logic        [mte_pkg::GAIN_W-1:0]          decay_gain,
    input  logic signed [mte_pkg::SAMPLE_BITS-1:0]     rd_data,
    output logic signed [mte_pkg::ACC_W-1:0]           acc,
    output logic                                       busy
);

    localparam int GW     = mte_pkg::GAIN_W;
    localparam int PROD_W = mte_pkg::SAMPLE_BITS + GW + 1;
    localparam int AW     = mte_pkg::ACC_W;

    logic [GW-1:0]            gain_reg;
    logic [2*GW-1:0]          gain_prod;
    logic                     s1_valid_reg;
    logic                     s1_use_reg;
    logic [GW-1:0]            s1_gain_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [PROD_W-1:0] tap_prod;
    logic signed [AW-1:0]     acc_reg;

    // next power of the decay, floored back to Q0.16
    assign gain_prod = gain_reg * decay_gain;
    assign tap_prod  = $signed({1'b0, s1_gain_reg}) * rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            gain_reg <= decay_gain;
        end
        else if (ctl.issue)
        begin
            gain_reg <= gain_prod[2*GW-1:GW];
        end

        if (ctl.issue)
        begin
            s1_use_reg  <= ctl.use_tap;
            s1_gain_reg <= gain_reg;
        end

        // history data lands in the cycle after the read was issued
        if (s1_valid_reg)
        begin
            s2_prod_reg <= s1_use_reg ? tap_prod : '0;
        end

        if (ctl.load)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + {{(AW-PROD_W){s2_prod_reg[PROD_W-1]}}, s2_prod_reg};
        end
    end

    assign acc  = acc_reg;
    assign busy = s1_valid_reg | s2_valid_reg;

endmodule

// File: rtl/mte_mix_sat.sv
`timescale 1ns / 1ps

module mte_mix_sat (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [mte_pkg::ACC_W-1:0]       acc,
    input  logic        [mte_pkg::MIX_W-1:0]       mix,
    input  logic signed [mte_pkg::SAMPLE_BITS-1:0] dry,
    output logic                                   done,
    output logic signed [mte_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   clipped
);

    localparam int SB    = mte_pkg::SAMPLE_BITS;
    localparam int AW    = mte_pkg::ACC_W;
    localparam int LO_W  = 18;
    localparam int HI_W  = AW - LO_W;
    localparam int MP_W  = HI_W + mte_pkg::MIX_W + 1;
    localparam int SUM_W = AW + mte_pkg::MIX_W + 1;
    localparam int WET_W = SUM_W - mte_pkg::FRAC_SHIFT;
    localparam int Y_W   = WET_W + 1;

    localparam logic signed [Y_W-1:0] SAT_HI = Y_W'((2 ** (SB - 1)) - 1);
    localparam logic signed [Y_W-1:0] SAT_LO = ~SAT_HI;

    logic [2:0]                phase_reg;
    logic                      done_reg;
    logic signed [HI_W-1:0]    mult_a;
    logic signed [MP_W-1:0]    mult_p;
    logic signed [MP_W-1:0]    plo_reg;
    logic signed [MP_W-1:0]    phi_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   wet_full;
    logic signed [Y_W-1:0]     y_full;
    logic signed [SB-1:0]      sample_reg;
    logic                      clipped_reg;

    // one shared multiplier: low part of the sum first, then the signed high part
    assign mult_a = start ? $signed({1'b0, acc[LO_W-1:0]}) : $signed(acc[AW-1:LO_W]);
    assign mult_p = mult_a * $signed({1'b0, mix});

    assign sum_next = $signed({phi_reg, {LO_W{1'b0}}})
                    + {{(SUM_W-MP_W){plo_reg[MP_W-1]}}, plo_reg};

    // arithmetic shift floors toward minus infinity
    assign wet_full = sum_reg >>> mte_pkg::FRAC_SHIFT;
    assign y_full   = {wet_full[WET_W-1], wet_full[WET_W-1:0]}
                    + {{(Y_W-SB){dry[SB-1]}}, dry};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= {phase_reg[1:0], start};
            done_reg  <= phase_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            plo_reg <= mult_p;
        end
        if (phase_reg[0])
        begin
            phi_reg <= mult_p;
        end
        if (phase_reg[1])
        begin
            sum_reg <= sum_next;
        end
        if (phase_reg[2])
        begin
            if (y_full > SAT_HI)
            begin
                sample_reg  <= SAT_HI[SB-1:0];
                clipped_reg <= 1'b1;
            end
            else if (y_full < SAT_LO)
            begin
                sample_reg  <= SAT_LO[SB-1:0];
                clipped_reg <= 1'b1;
            end
            else
            begin
                sample_reg  <= y_full[SB-1:0];
                clipped_reg <= 1'b0;
            end
        end
    end

    assign done    = done_reg;
    assign sample  = sample_reg;
    assign clipped = clipped_reg;

endmodule

// File: rtl/multi_tap_echo_unit.sv
`timescale 1ns / 1ps

// Multi-tap echo: each beat on item carries one signed Q1.15 sample and gives one
// result beat, the dry sample plus wet_mix times the sum of decay^i weighted past
// samples spaced delay_samples apart, floored to Q1.15 and saturated (clipped set).
// Taps that reach before the start of the current clip or beyond the history store
// add nothing; last_sample ends a clip. Past samples live in one single-port-read
// history memory and every echo tap in range costs one read of it. A new item is
// taken only in the idle state, once the last result has gone to the output
// register. The history memory needs no clearing after reset.
// Configuration writes belong to idle periods; cfg_ready is always high.

module multi_tap_echo_unit #(
    parameter int MAX_DELAY     = 4096,
    parameter int MAX_ECHO      = 30,
    parameter int HISTORY_DEPTH = 131072
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mte_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  mte_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output mte_pkg::result_t                      result
);

    localparam int SB  = mte_pkg::SAMPLE_BITS;
    localparam int CNW = mte_pkg::COUNT_W;
    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int SW  = $clog2(HISTORY_DEPTH + 1);
    localparam int DW  = $clog2(MAX_DELAY + 1);
    localparam int RW  = $clog2((MAX_ECHO + 1) * MAX_DELAY + 1);
    localparam int CW  = (RW > SW) ? RW : SW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TAP   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_MIX   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;

    logic [mte_pkg::DELAY_W-1:0]       delay_reg;
    logic [mte_pkg::GAIN_W-1:0]        decay_reg;
    logic [CNW-1:0]                    count_reg;
    logic [mte_pkg::MIX_W-1:0]         mix_reg;

    logic [DW-1:0]                     d_eff;
    logic [CNW-1:0]                    taps_eff;
    logic [CNW-1:0]                    taps_last;
    logic [mte_pkg::MIX_W-1:0]         mix_eff;

    mte_pkg::item_t                    item_reg;
    logic [AW-1:0]                     wp_reg;
    logic [SW-1:0]                     seen_reg;
    logic [RW-1:0]                     reach_reg;
    logic [CNW-1:0]                    tap_idx_reg;
    logic                              out_valid_reg;
    mte_pkg::result_t                  result_reg;

    logic                              accept;
    logic [CW-1:0]                     reach_c;
    logic [AW-1:0]                     reach_a;
    logic [AW:0]                       wrap_addr;
    logic                              tap_ok;
    logic [AW-1:0]                     rd_addr;
    logic                              rd_en;
    logic [SB-1:0]                     rd_data;
    mte_pkg::tap_ctl_t                 tap_ctl;
    logic signed [mte_pkg::ACC_W-1:0]  acc;
    logic                              tap_busy;
    logic                              mix_start;
    logic                              mix_done;
    logic signed [SB-1:0]              mix_sample;
    logic                              mix_clipped;
    logic                              out_load;

    // register limits as the datapath sees them
    always_comb
    begin
        if (delay_reg == '0)
        begin
            d_eff = DW'(1);
        end
        else if (int'(delay_reg) > MAX_DELAY)
        begin
            d_eff = DW'(MAX_DELAY);
        end
        else
        begin
            d_eff = DW'(delay_reg);
        end

        if (count_reg == '0)
        begin
            taps_eff = CNW'(1);
        end
        else if (int'(count_reg) > MAX_ECHO)
        begin
            taps_eff = CNW'(MAX_ECHO);
        end
        else
        begin
            taps_eff = count_reg;
        end
        taps_last = taps_eff - CNW'(1);

        mix_eff = (mix_reg > mte_pkg::MIX_UNITY) ? mte_pkg::MIX_UNITY : mix_reg;
    end

    assign cfg_ready  = 1'b1;
    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid & item_ready;

    // tap address: current slot minus reach, modulo the store depth
    assign reach_c   = CW'(reach_reg);
    assign reach_a   = reach_c[AW-1:0];
    assign tap_ok    = (reach_c <= CW'(seen_reg)) && (reach_c < CW'(HISTORY_DEPTH));
    assign wrap_addr = {1'b0, wp_reg} + (AW + 1)'(HISTORY_DEPTH) - {1'b0, reach_a};
    assign rd_addr   = (wp_reg >= reach_a) ? (wp_reg - reach_a) : wrap_addr[AW-1:0];

    assign tap_ctl.load    = accept;
    assign tap_ctl.issue   = (state_reg == S_TAP);
    assign tap_ctl.use_tap = tap_ok;
    assign rd_en           = tap_ctl.issue & tap_ok;

    assign mix_start = (state_reg == S_DRAIN) && !tap_busy;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || result_ready);

    mte_ram #(
        .WIDTH (SB),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (out_load),
        .wr_addr (wp_reg),
        .wr_data (item_reg.in_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mte_tap_mac u_tap_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tap_ctl),
        .decay_gain (decay_reg),
        .rd_data    ($signed(rd_data)),
        .acc        (acc),
        .busy       (tap_busy)
    );

    mte_mix_sat u_mix_sat (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mix_start),
        .acc     (acc),
        .mix     (mix_eff),
        .dry     (item_reg.in_sample),
        .done    (mix_done),
        .sample  (mix_sample),
        .clipped (mix_clipped)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (taps_eff == CNW'(1)) ? S_DRAIN : S_TAP;
                end
            end
            S_TAP:
            begin
                if (tap_idx_reg == taps_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!tap_busy)
                begin
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                if (mix_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delay_reg     <= mte_pkg::DELAY_RESET;
            decay_reg     <= mte_pkg::DECAY_RESET;
            count_reg     <= mte_pkg::COUNT_RESET;
            mix_reg       <= mte_pkg::MIX_RESET;
            wp_reg        <= '0;
            seen_reg      <= '0;
            tap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    mte_pkg::CFG_DELAY: delay_reg <= cfg_data[mte_pkg::DELAY_W-1:0];
                    mte_pkg::CFG_DECAY: decay_reg <= cfg_data;
                    mte_pkg::CFG_COUNT: count_reg <= cfg_data[CNW-1:0];
                    mte_pkg::CFG_MIX:   mix_reg   <= cfg_data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                tap_idx_reg <= CNW'(1);
            end
            else if (tap_ctl.issue)
            begin
                tap_idx_reg <= tap_idx_reg + CNW'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                wp_reg <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (item_reg.last_sample)
                begin
                    seen_reg <= '0;
                end
                else if (seen_reg < SW'(HISTORY_DEPTH))
                begin
                    seen_reg <= seen_reg + SW'(1);
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= item;
            reach_reg <= RW'(d_eff);
        end
        else if (tap_ctl.issue)
        begin
            reach_reg <= reach_reg + RW'(d_eff);
        end

        if (out_load)
        begin
            result_reg.out_sample  <= mix_sample;
            result_reg.clipped     <= mix_clipped;
            result_reg.end_of_clip <= item_reg.last_sample;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/mte_checker.sv
`timescale 1ns / 1ps

module mte_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input mte_pkg::result_t result
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       item_beat;
    logic       result_beat;

    assign item_beat   = item_valid & item_ready;
    assign result_beat = result_valid & result_ready;

    // items taken but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (item_beat && !result_beat && pend_reg != 2'd3)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!item_beat && result_beat && pend_reg != 2'd0)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    property p_result_hold;
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result);
    endproperty

    property p_one_item_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        item_beat |=> !item_ready;
    endproperty

    property p_no_spurious_result;
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0;
    endproperty

    property p_at_most_two_in_flight;
        @(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3;
    endproperty

    property p_clip_at_rail;
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.clipped |->
            (result.out_sample == 16'sh7fff) || (result.out_sample == -16'sh8000);
    endproperty

    a_result_hold: assert property (p_result_hold)
        else $error("result beat changed while stalled");
    a_one_item_at_a_time: assert property (p_one_item_at_a_time)
        else $error("second item taken while one is in work");
    a_no_spurious_result: assert property (p_no_spurious_result)
        else $error("result offered with no item outstanding");
    a_at_most_two_in_flight: assert property (p_at_most_two_in_flight)
        else $error("more than two items held in the block");
    a_clip_at_rail: assert property (p_clip_at_rail)
        else $error("clipped result not at a rail");

endmodule

bind multi_tap_echo_unit mte_checker u_mte_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int HIST_DEPTH  = 131072;
    localparam int DELAY_MAX   = 4096;
    localparam int TAPS_MAX    = 30;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 64;
    localparam int IDX_W       = mte_pkg::CFG_IDX_W;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mte_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mte_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    mte_pkg::item_t                 item = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    mte_pkg::result_t               result;

    // shadow of the block's registers and history
    logic [mte_pkg::DELAY_W-1:0] cur_delay = mte_pkg::DELAY_RESET;
    logic [mte_pkg::GAIN_W-1:0]  cur_decay = mte_pkg::DECAY_RESET;
    logic [mte_pkg::COUNT_W-1:0] cur_count = mte_pkg::COUNT_RESET;
    logic [mte_pkg::MIX_W-1:0]   cur_mix   = mte_pkg::MIX_RESET;
    logic signed [15:0]          hist_mem [0:HIST_DEPTH-1];
    logic [16:0]                 wr_ptr = '0;
    int unsigned                 clip_seen = 0;

    mte_pkg::result_t echo_out_q[$];
    mte_pkg::result_t want;
    int      errors = 0;
    int      cycles = 0;
    int      tx_idle_pct = 35;
    int      rx_idle_pct = 35;
    int      rx_hold = 0;

    multi_tap_echo_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // echo sum for one sample, then advance the history
    function automatic mte_pkg::result_t echo_mix(input mte_pkg::item_t it);
        longint signed    x;
        longint signed    acc;
        longint signed    y;
        longint unsigned  g;
        longint unsigned  dly;
        longint unsigned  taps;
        longint unsigned  mix;
        longint unsigned  reach;
        logic [16:0]      rd_ptr;
        mte_pkg::result_t r;
        x    = it.in_sample;
        acc  = 0;
        dly  = cur_delay;
        taps = cur_count;
        mix  = cur_mix;
        g    = cur_decay;
        if (dly < 1) dly = 1;
        if (dly > DELAY_MAX) dly = DELAY_MAX;
        if (taps < 1) taps = 1;
        if (taps > TAPS_MAX) taps = TAPS_MAX;
        if (mix > 32768) mix = 32768;
        for (int i = 1; i < taps; i++)
        begin
            reach = i * dly;
            if (i > 1)
                g = (g * cur_decay) >> 16;
            // only taps inside the current clip contribute
            if (reach <= clip_seen && reach < HIST_DEPTH)
            begin
                rd_ptr = wr_ptr - reach[16:0];
                acc += longint'(g) * longint'(hist_mem[rd_ptr]);
            end
        end
        y = x + ((acc * longint'(mix)) >>> 31);
        r.clipped = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            r.clipped = 1'b1;
        end
        if (y < -32768)
        begin
            y = -32768;
            r.clipped = 1'b1;
        end
        r.out_sample  = y[15:0];
        r.end_of_clip = it.last_sample;
        hist_mem[wr_ptr] = it.in_sample;
        wr_ptr = wr_ptr + 17'd1;
        if (it.last_sample)
            clip_seen = 0;
        else if (clip_seen < HIST_DEPTH)
            clip_seen++;
        return r;
    endfunction

    function automatic mte_pkg::item_t rand_sample();
        mte_pkg::item_t     it;
        logic signed [15:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2: s = 16'($urandom);
            3:       s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            4, 5, 6: s = 16'($urandom_range(0, 511) - 256);
            default:
            begin
                s = 16'($urandom_range(12000, 32767));
                if ($urandom_range(0, 1))
                    s = -s;
            end
        endcase
        it.in_sample   = s;
        it.last_sample = ($urandom_range(0, 39) == 0);
        return it;
    endfunction

    function automatic mte_pkg::item_t mk_sample(input int v, input logic last);
        mte_pkg::item_t it;
        it.in_sample   = 16'(v);
        it.last_sample = last;
        return it;
    endfunction

    // enters and leaves on a falling edge; valid stays up for a following beat
    task automatic send_item(input mte_pkg::item_t it);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 60);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        echo_out_q.push_back(echo_mix(it));
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (echo_out_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [mte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            mte_pkg::CFG_DELAY: cur_delay = data[mte_pkg::DELAY_W-1:0];
            mte_pkg::CFG_DECAY: cur_decay = data;
            mte_pkg::CFG_COUNT: cur_count = data[mte_pkg::COUNT_W-1:0];
            mte_pkg::CFG_MIX:   cur_mix   = data;
            default:   ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] dly, input logic [15:0] dec,
                                  input logic [15:0] cnt, input logic [15:0] mix);
        wait_drained();
        write_reg(mte_pkg::CFG_DELAY, dly);
        write_reg(mte_pkg::CFG_DECAY, dec);
        write_reg(mte_pkg::CFG_COUNT, cnt);
        write_reg(mte_pkg::CFG_MIX, mix);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (echo_out_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got %h", $time, result);
                errors++;
            end
            else
            begin
                want = echo_out_q.pop_front();
                if (result.out_sample !== want.out_sample)
                begin
                    $display("%0t: out_sample expected %0d got %0d", $time,
                             $signed(want.out_sample), $signed(result.out_sample));
                    errors++;
                end
                if (result.clipped !== want.clipped)
                begin
                    $display("%0t: clipped expected %b got %b", $time,
                             want.clipped, result.clipped);
                    errors++;
                end
                if (result.end_of_clip !== want.end_of_clip)
                begin
                    $display("%0t: end_of_clip expected %b got %b", $time,
                             want.end_of_clip, result.end_of_clip);
                    errors++;
                end
            end
        end
    end

    // default registers: the taps are too far away to reach anything yet
    task automatic test_reset_setting();
        send_item(mk_sample(32767, 1'b0));
        send_item(mk_sample(-32768, 1'b0));
        send_item(mk_sample(0, 1'b1));
    endtask

    task automatic test_extremes();
        // count and mix above range act as their maxima, delay one
        apply_settings(16'd1, 16'hffff, 16'd31, 16'hffff);
        repeat (4) send_item(mk_sample(32767, 1'b0));
        send_item(mk_sample(-32768, 1'b0));
        send_item(mk_sample(-32768, 1'b0));
        send_item(mk_sample(-32768, 1'b1));
        // zero delay acts as one, zero count is dry only
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(mk_sample(-1, 1'b0));
        send_item(mk_sample(1, 1'b0));
        // delay above range, upper data bits dropped
        apply_settings(16'hffff, 16'd32768, 16'd2, 16'd32768);
        send_item(mk_sample(20000, 1'b0));
        send_item(mk_sample(20000, 1'b1));
        // unused register indexes must leave the settings alone
        apply_settings(16'd1, 16'd32768, 16'd3, 16'd32768);
        for (int k = int'(mte_pkg::CFG_MIX) + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), 16'(k));
        cfg_valid <= 1'b0;
        send_item(mk_sample(-1, 1'b0));
        send_item(mk_sample(1, 1'b0));
        send_item(mk_sample(-3, 1'b0));
        send_item(mk_sample(32767, 1'b0));
        send_item(mk_sample(-32768, 1'b0));
        send_item(mk_sample(-32768, 1'b1));
    endtask

    task automatic test_random_phases();
        logic [15:0] dly;
        logic [15:0] dec;
        logic [15:0] cnt;
        logic [15:0] mix;
        for (int p = 0; p < 6; p++)
        begin
            case ($urandom_range(0, 5))
                0:       dly = 16'd1;
                1:       dly = 16'($urandom_range(2, 8));
                2:       dly = 16'($urandom_range(9, 40));
                3:       dly = 16'd0;
                4:       dly = 16'($urandom_range(4097, 8191));
                default: dly = 16'($urandom_range(1, 100));
            endcase
            dly = dly | (16'($urandom) & 16'he000);
            case ($urandom_range(0, 3))
                0:       dec = 16'd0;
                1:       dec = 16'hffff;
                default: dec = 16'($urandom);
            endcase
            cnt = 16'($urandom_range(0, 31)) | (16'($urandom) & 16'hffe0);
            case ($urandom_range(0, 4))
                0:       mix = 16'd0;
                1:       mix = mte_pkg::MIX_UNITY;
                2:       mix = 16'hffff;
                default: mix = 16'($urandom);
            endcase
            apply_settings(dly, dec, cnt, mix);
            repeat (105) send_item(rand_sample());
        end
    endtask

    task automatic test_no_idle();
        apply_settings(16'd3, 16'd50000, 16'd12, mte_pkg::MIX_UNITY);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (100) send_item(rand_sample());
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    task automatic test_backpressure();
        apply_settings(16'd2, 16'd40000, 16'd8, 16'd30000);
        // receiver holds off while the sender keeps offering beats
        rx_hold     = 300;
        tx_idle_pct = 0;
        repeat (24) send_item(rand_sample());
        tx_idle_pct = 35;
        wait_drained();
        repeat (30) send_item(rand_sample());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_setting();
        test_extremes();
        test_random_phases();
        test_no_idle();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
